FILE: rtl/window_frame_pixel_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Window frame pixel generator: assertion macros
// Shared property forms for the checker of the window frame pixel generator.
// ----------------------------------------------------------------------------
`ifndef WINDOW_FRAME_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define WINDOW_FRAME_PIXEL_GENERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WFPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WFPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wfpg_pkg.sv
// ----------------------------------------------------------------------------
// Window frame pixel generator package
// Geometry constants, colour constants, register indices and shading tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfpg_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int CORNER_RADIUS = 6;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int COLOR_W = 32;

    localparam int MIN_SIZE   = 30;
    localparam int TITLE_ROWS = 18;
    localparam int BTN_TOP    = 3;
    localparam int BTN_SIZE   = 10;
    localparam int CLOSE_OFF  = 14;
    localparam int MAXI_OFF   = 28;

    localparam logic [COLOR_W-1:0] FRAME_RGB = 32'h0022_2222;
    localparam logic [COLOR_W-1:0] CLEAR_RGB = 32'hFFFF_FFFF;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WIDTH     = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT    = 2'd1;
    localparam t_cfg_idx CFG_BASE      = 2'd2;
    localparam t_cfg_idx CFG_MAXIMISED = 2'd3;

    // floor(255 * (10 - r) / 10) for button row r.
    function automatic logic [7:0] shade_full(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd0: v = 8'hFF;
            4'd1: v = 8'hE5;
            4'd2: v = 8'hCC;
            4'd3: v = 8'hB2;
            4'd4: v = 8'h99;
            4'd5: v = 8'h7F;
            4'd6: v = 8'h66;
            4'd7: v = 8'h4C;
            4'd8: v = 8'h33;
            4'd9: v = 8'h19;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // floor(0x44 * (10 - r) / 10) for button row r.
    function automatic logic [7:0] shade_part(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd0: v = 8'h44;
            4'd1: v = 8'h3D;
            4'd2: v = 8'h36;
            4'd3: v = 8'h2F;
            4'd4: v = 8'h28;
            4'd5: v = 8'h22;
            4'd6: v = 8'h1B;
            4'd7: v = 8'h14;
            4'd8: v = 8'h0D;
            4'd9: v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // floor(3c/4) for one colour channel.
    function automatic logic [7:0] darken(input logic [7:0] c);
        logic [9:0] t;
        t = {2'b00, c} + {1'b0, c, 1'b0};
        return t[9:2];
    endfunction

    // True when the offset from the arc centre lies beyond the corner radius.
    function automatic logic corner_out(input logic [3:0] dx, input logic [3:0] dy);
        logic [7:0] s;
        s = 8'(dx) * 8'(dx) + 8'(dy) * 8'(dy);
        return s > 8'(CORNER_RADIUS * CORNER_RADIUS);
    endfunction

endpackage

FILE: rtl/window_frame_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// Window frame pixel generator
// Decides per pixel whether the window decoration writes it, and the colour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One pixel coordinate is taken per clock unless the output stalls; the
// coordinate is registered, the decoration logic is combinational on it, and
// the result register holds it for the output stream. The input stays ready
// while the result register is empty or being drained, so a stalled output
// holds one result and one coordinate before the input stalls. The user must
// write window size, base colour and maximised flag through the configuration
// port while no pixel is in flight; the block itself does not enforce this.
module window_frame_pixel_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] pixel_color
    output logic        m_axis_tuser    // [0] write_enable
);

    localparam int DW = wfpg_pkg::DIM_W;

    logic [DW-1:0]                  r_width;
    logic [DW-1:0]                  r_height;
    logic [wfpg_pkg::COLOR_W-1:0]   r_base;
    logic                           r_max;

    logic                           r_in_valid;
    logic [wfpg_pkg::COORD_W-1:0]   r_x;
    logic [wfpg_pkg::COORD_W-1:0]   r_y;
    logic                           r_out_valid;
    logic                           r_we;
    logic [wfpg_pkg::COLOR_W-1:0]   r_color;

    logic                           out_load;
    logic                           in_load;
    logic                           n_we;
    logic [wfpg_pkg::COLOR_W-1:0]   n_color;

    logic [DW-1:0] w, h, xe, ye, rad;
    logic          size_ok, in_win, title, left, right, top;
    logic [3:0]    dx_l, dx_r, dy_t, btn_r;
    logic          mask_in, btn_row, close_col, maxi_col, frame_h, frame_v;
    logic [wfpg_pkg::COLOR_W-1:0] bar_color;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_base   <= '0;
            r_max    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wfpg_pkg::CFG_WIDTH:     r_width  <= i_cfg_data[DW-1:0];
                wfpg_pkg::CFG_HEIGHT:    r_height <= i_cfg_data[DW-1:0];
                wfpg_pkg::CFG_BASE:      r_base   <= i_cfg_data;
                wfpg_pkg::CFG_MAXIMISED: r_max    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Two-stage handshake: each stage loads when empty or the next can take.
    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_x <= s_axis_tdata[11:0];
            r_y <= s_axis_tdata[23:12];
        end
        if (out_load && r_in_valid) begin
            r_we    <= n_we;
            r_color <= n_color;
        end
    end

    // Decoration logic on the registered coordinate.
    always_comb begin
        w   = (r_width  > DW'(wfpg_pkg::MAX_DIM)) ? DW'(wfpg_pkg::MAX_DIM) : r_width;
        h   = (r_height > DW'(wfpg_pkg::MAX_DIM)) ? DW'(wfpg_pkg::MAX_DIM) : r_height;
        xe  = {1'b0, r_x};
        ye  = {1'b0, r_y};
        rad = DW'(wfpg_pkg::CORNER_RADIUS);

        size_ok = (w >= DW'(wfpg_pkg::MIN_SIZE)) && (h >= DW'(wfpg_pkg::MIN_SIZE));
        in_win  = (xe < w) && (ye < h);
        title   = ye < DW'(wfpg_pkg::TITLE_ROWS);

        // The bottom corners lie below the title bar for every legal window
        // size, so only the top corners bear on the mask.
        left  = xe < rad;
        right = xe >= w - rad;
        top   = ye < rad;
        dx_l  = 4'(rad - xe);
        dx_r  = 4'(xe - (w - rad - DW'(1)));
        dy_t  = 4'(rad - ye);
        mask_in = r_max ||
                  !((left  && top && wfpg_pkg::corner_out(dx_l, dy_t)) ||
                    (right && top && wfpg_pkg::corner_out(dx_r, dy_t)));

        btn_row   = (ye >= DW'(wfpg_pkg::BTN_TOP)) &&
                    (ye <  DW'(wfpg_pkg::BTN_TOP + wfpg_pkg::BTN_SIZE));
        btn_r     = 4'(ye - DW'(wfpg_pkg::BTN_TOP));
        close_col = (xe >= w - DW'(wfpg_pkg::CLOSE_OFF)) &&
                    (xe <  w - DW'(wfpg_pkg::CLOSE_OFF - wfpg_pkg::BTN_SIZE));
        maxi_col  = (xe >= w - DW'(wfpg_pkg::MAXI_OFF)) &&
                    (xe <  w - DW'(wfpg_pkg::MAXI_OFF - wfpg_pkg::BTN_SIZE));

        if (!mask_in) begin
            bar_color = wfpg_pkg::CLEAR_RGB;
        end else if (ye == '0) begin
            bar_color = {8'h00, wfpg_pkg::darken(r_base[23:16]),
                         wfpg_pkg::darken(r_base[15:8]), wfpg_pkg::darken(r_base[7:0])};
        end else begin
            bar_color = r_base;
        end
        if (mask_in && btn_row) begin
            if (close_col) begin
                bar_color = {8'h00, wfpg_pkg::shade_full(btn_r),
                             wfpg_pkg::shade_part(btn_r), wfpg_pkg::shade_part(btn_r)};
            end else if (maxi_col) begin
                bar_color = {8'h00, wfpg_pkg::shade_part(btn_r),
                             wfpg_pkg::shade_full(btn_r), wfpg_pkg::shade_part(btn_r)};
            end
        end

        frame_h = ((ye == '0) || (ye == h - DW'(1))) && (xe >= rad) && (xe < w - rad);
        frame_v = ((xe == '0) || (xe == w - DW'(1))) && (ye >= rad) && (ye < h - rad);

        n_we = size_ok && in_win && (title || frame_h || frame_v);
        if (!n_we) begin
            n_color = '0;
        end else if (frame_h || frame_v) begin
            n_color = wfpg_pkg::FRAME_RGB;
        end else begin
            n_color = bar_color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_color;
    assign m_axis_tuser  = r_we;

endmodule

FILE: rtl/wfpg_checker.sv
// ----------------------------------------------------------------------------
// Window frame pixel generator checker
// Port-level properties of the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "window_frame_pixel_generator_top_assert.svh"

module wfpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A result that is not taken stays on the bus unchanged.
    `WFPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A pixel that is not written carries a zero colour.
    `WFPG_ASSERT_SAME(a_idle_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'h0, "unwritten pixel has non-zero colour")

    // An accepted pixel reaches the output once the output stage can drain.
    `WFPG_ASSERT_NEXT(a_latency, i_clk, i_rst_n, $past(s_axis_tvalid && s_axis_tready) && m_axis_tready, m_axis_tvalid, "accepted pixel lost in pipeline")

    // An empty output stage never holds the input back.
    `WFPG_ASSERT_SAME(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind window_frame_pixel_generator_top wfpg_checker u_wfpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Window frame pixel generator testbench
// Streams pixel coordinates through the decoration block under a range of
// window settings and compares every result with a behavioural prediction of
// the frame, title bar, rounded corners and button shading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [31:0] CLOSE_BTN_RGB  = 32'h00FF_4444;
    localparam logic [31:0] MAXIMISE_COLOR = 32'h0044_FF44;
    localparam int          STALL_LIMIT    = 3000;
    localparam int          SEGMENT_PIXELS = 50;
    localparam int          PHASE_SEGMENTS = 13;

    typedef struct packed {
        logic        we;
        logic [31:0] color;
    } t_pix_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [11:0] pixel_x, [23:12] pixel_y
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] pixel_color
    logic        m_axis_tuser;   // [0] write_enable

    // Shadow copy of the window settings held by the block.
    logic [12:0] win_width;
    logic [12:0] win_height;
    logic [31:0] win_base;
    logic        win_maximised;

    t_pix_result expected_pixels[$];
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          rcv_hold_cycles;
    int          error_count;
    int          pixels_sent;
    int          results_checked;
    int          settings_used;
    int          stall_cycles;

    window_frame_pixel_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [31:0] scale_color(input logic [31:0] c, input int num,
                                                input int den);
        int red;
        int green;
        int blue;
        red   = c[23:16] * num / den;
        green = c[15:8] * num / den;
        blue  = c[7:0] * num / den;
        return {8'h00, red[7:0], green[7:0], blue[7:0]};
    endfunction

    function automatic logic beyond_arc(input int dx, input int dy);
        return dx * dx + dy * dy > wfpg_pkg::CORNER_RADIUS * wfpg_pkg::CORNER_RADIUS;
    endfunction

    function automatic logic in_corner_mask(input int x, input int y, input int w,
                                            input int h);
        int  r = wfpg_pkg::CORNER_RADIUS;
        logic at_left;
        logic at_right;
        logic at_top;
        logic at_bottom;
        at_left   = x < r;
        at_right  = x >= w - r;
        at_top    = y < r;
        at_bottom = y >= h - r;
        if (win_maximised) return 1'b1;
        if (at_left && at_top && beyond_arc(r - x, r - y)) return 1'b0;
        if (at_right && at_top && beyond_arc(x - (w - r - 1), r - y)) return 1'b0;
        if (at_left && at_bottom && beyond_arc(r - x, y - (h - r - 1))) return 1'b0;
        if (at_right && at_bottom && beyond_arc(x - (w - r - 1), y - (h - r - 1)))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_pix_result predict_pixel(input logic [11:0] px,
                                                  input logic [11:0] py);
        t_pix_result res;
        int          x;
        int          y;
        int          w;
        int          h;
        int          shade;
        logic        in_mask;
        x   = px;
        y   = py;
        w   = (win_width > wfpg_pkg::MAX_DIM) ? wfpg_pkg::MAX_DIM : win_width;
        h   = (win_height > wfpg_pkg::MAX_DIM) ? wfpg_pkg::MAX_DIM : win_height;
        res = '0;
        if (w >= wfpg_pkg::MIN_SIZE && h >= wfpg_pkg::MIN_SIZE && x < w && y < h) begin
            if (y < wfpg_pkg::TITLE_ROWS) begin
                in_mask = in_corner_mask(x, y, w, h);
                res.we  = 1'b1;
                if (!in_mask) begin
                    res.color = wfpg_pkg::CLEAR_RGB;
                end else if (y == 0) begin
                    res.color = scale_color(win_base, 3, 4);
                end else begin
                    res.color = win_base;
                end
                if (in_mask && y >= wfpg_pkg::BTN_TOP &&
                    y < wfpg_pkg::BTN_TOP + wfpg_pkg::BTN_SIZE) begin
                    shade = wfpg_pkg::BTN_SIZE - (y - wfpg_pkg::BTN_TOP);
                    if (x >= w - wfpg_pkg::CLOSE_OFF &&
                        x < w - wfpg_pkg::CLOSE_OFF + wfpg_pkg::BTN_SIZE) begin
                        res.color = scale_color(CLOSE_BTN_RGB, shade, wfpg_pkg::BTN_SIZE);
                    end else if (x >= w - wfpg_pkg::MAXI_OFF &&
                                 x < w - wfpg_pkg::MAXI_OFF + wfpg_pkg::BTN_SIZE) begin
                        res.color = scale_color(MAXIMISE_COLOR, shade, wfpg_pkg::BTN_SIZE);
                    end
                end
            end
            // Frame lines override everything drawn beneath them.
            if ((y == 0 || y == h - 1) && x >= wfpg_pkg::CORNER_RADIUS &&
                x < w - wfpg_pkg::CORNER_RADIUS) begin
                res.we    = 1'b1;
                res.color = wfpg_pkg::FRAME_RGB;
            end
            if ((x == 0 || x == w - 1) && y >= wfpg_pkg::CORNER_RADIUS &&
                y < h - wfpg_pkg::CORNER_RADIUS) begin
                res.we    = 1'b1;
                res.color = wfpg_pkg::FRAME_RGB;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result we=%0b color=%08h", $time,
                         m_axis_tuser, m_axis_tdata);
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tuser !== want.we) begin
                    error_count++;
                    $display("%0t: write_enable expected %0b, actual %0b", $time,
                             want.we, m_axis_tuser);
                end
                if (m_axis_tdata !== want.color) begin
                    error_count++;
                    $display("%0t: pixel_color expected %08h, actual %08h", $time,
                             want.color, m_axis_tdata);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rcv_hold_cycles > 0) begin
            rcv_hold_cycles = rcv_hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic cfg_write(input wfpg_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            wfpg_pkg::CFG_WIDTH:     win_width     = val[12:0];
            wfpg_pkg::CFG_HEIGHT:    win_height    = val[12:0];
            wfpg_pkg::CFG_BASE:      win_base      = val;
            wfpg_pkg::CFG_MAXIMISED: win_maximised = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(input int w, input int h, input logic [31:0] base,
                              input logic maxd);
        cfg_write(wfpg_pkg::CFG_WIDTH, w);
        cfg_write(wfpg_pkg::CFG_HEIGHT, h);
        cfg_write(wfpg_pkg::CFG_BASE, base);
        cfg_write(wfpg_pkg::CFG_MAXIMISED, {31'd0, maxd});
        settings_used++;
    endtask

    // Leaves tvalid high on return so that back-to-back transfers need no gap.
    task automatic send_pixel(input int x, input int y);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y[11:0], x[11:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pixels.push_back(predict_pixel(x[11:0], y[11:0]));
        pixels_sent++;
    endtask

    task automatic end_burst_and_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Random coordinates, biased towards the decorated parts of the window
    // ------------------------------------------------------------------------
    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    function automatic int edge_coord(input int span, input int depth);
        if ($urandom_range(1)) return clamp_coord($urandom_range(0, 7));
        return clamp_coord(span - 1 - int'($urandom_range(0, depth)));
    endfunction

    task automatic random_pixel(output int x, output int y);
        int sw;
        int sh;
        int sel;
        sw  = (win_width < 1) ? 1 :
              ((win_width > wfpg_pkg::MAX_DIM) ? wfpg_pkg::MAX_DIM : win_width);
        sh  = (win_height < 1) ? 1 :
              ((win_height > wfpg_pkg::MAX_DIM) ? wfpg_pkg::MAX_DIM : win_height);
        sel = $urandom_range(99);
        if (sel < 35) begin
            x = $urandom_range(1) ? edge_coord(sw, 31) : clamp_coord($urandom_range(0, sw - 1));
            y = $urandom_range(0, wfpg_pkg::TITLE_ROWS - 1);
        end else if (sel < 55) begin
            x = edge_coord(sw, 7);
            y = $urandom_range(1) ? edge_coord(sh, 7) : clamp_coord($urandom_range(0, sh - 1));
        end else if (sel < 80) begin
            x = clamp_coord($urandom_range(0, sw - 1));
            y = clamp_coord($urandom_range(0, sh - 1));
        end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
        end
    endtask

    function automatic int random_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return $urandom_range(wfpg_pkg::MIN_SIZE, 300);
        if (sel < 80) return $urandom_range(0, wfpg_pkg::MIN_SIZE - 1);
        if (sel < 90) return $urandom_range(301, wfpg_pkg::MAX_DIM);
        return $urandom_range(0, 8191);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        // All configuration registers are zero, so nothing is decorated.
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        end_burst_and_drain();
    endtask

    task automatic test_small_window();
        set_window(wfpg_pkg::MIN_SIZE - 1, wfpg_pkg::MAX_DIM, 32'h00AB_CDEF, 1'b0);
        send_pixel(0, 10);
        end_burst_and_drain();
        set_window(wfpg_pkg::MAX_DIM, wfpg_pkg::MIN_SIZE - 1, 32'h00AB_CDEF, 1'b0);
        send_pixel(10, 0);
        end_burst_and_drain();
    endtask

    task automatic test_decoration();
        set_window(100, 60, 32'h80FF_7F01, 1'b0);
        send_pixel(0, 0);      // transparent corner
        send_pixel(5, 0);      // just outside the arc
        send_pixel(3, 3);      // inside the arc
        send_pixel(6, 0);      // first column of the top frame line
        send_pixel(0, 6);      // first row of the left frame line
        send_pixel(50, 1);
        send_pixel(50, 17);    // last title row
        send_pixel(50, 18);    // untouched interior
        send_pixel(86, 3);     // close button, top left
        send_pixel(95, 12);    // close button, bottom right
        send_pixel(96, 5);     // right of the close button
        send_pixel(72, 3);     // maximise button, top left
        send_pixel(81, 12);    // maximise button, bottom right
        send_pixel(82, 7);     // gap between the buttons
        send_pixel(99, 30);    // right frame line
        send_pixel(50, 59);    // bottom frame line
        send_pixel(99, 59);    // bottom right corner, below the title bar
        send_pixel(100, 0);    // outside the window
        end_burst_and_drain();
        set_window(100, 60, 32'h80FF_7F01, 1'b1);
        send_pixel(0, 0);      // darkened top row once the mask is off
        send_pixel(99, 17);
        send_pixel(4095, 4095);
        end_burst_and_drain();
    endtask

    task automatic test_output_backpressure();
        int x;
        int y;
        set_window(120, 80, $urandom, 1'b0);
        snd_idle_pct    = 0;
        rcv_idle_pct    = 0;
        rcv_hold_cycles = 60;
        repeat (40) begin
            random_pixel(x, y);
            send_pixel(x, y);
        end
        end_burst_and_drain();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
        int          x;
        int          y;
        int          w;
        int          h;
        logic [31:0] base;
        logic        maxd;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int seg = 0; seg < PHASE_SEGMENTS; seg++) begin
            w    = random_dim();
            h    = random_dim();
            base = $urandom;
            maxd = ($urandom_range(99) < 30);
            case ($urandom_range(5))
                0: base = 32'h0000_0000;
                1: base = 32'hFFFF_FFFF;
                default: ;
            endcase
            // Extremes of the settings appear at the start of every phase.
            case (seg)
                0: begin w = wfpg_pkg::MIN_SIZE; h = wfpg_pkg::MIN_SIZE; end
                1: begin w = wfpg_pkg::MAX_DIM; h = wfpg_pkg::MAX_DIM; end
                2: begin w = 8191; h = 5000; end
                3: begin w = 0; h = 0; end
                default: ;
            endcase
            set_window(w, h, base, maxd);
            repeat (SEGMENT_PIXELS) begin
                random_pixel(x, y);
                send_pixel(x, y);
            end
            end_burst_and_drain();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = wfpg_pkg::CFG_WIDTH;
        i_cfg_data      = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        win_width       = '0;
        win_height      = '0;
        win_base        = '0;
        win_maximised   = 1'b0;
        snd_idle_pct    = 12;
        rcv_idle_pct    = 83;
        rcv_hold_cycles = 0;
        error_count     = 0;
        pixels_sent     = 0;
        results_checked = 0;
        settings_used   = 0;
        stall_cycles    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_small_window();
        test_decoration();
        test_output_backpressure();
        test_random_traffic(12, 83);
        test_random_traffic(83, 12);
        test_random_traffic(0, 0);

        if (expected_pixels.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
        end
        $display("Sent %0d pixels under %0d window settings, %0d results checked,",
                 pixels_sent, settings_used, results_checked);
        $display("covering corners, title bar, buttons, frame lines and output stalls.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
